// ===== src/ipf_pkg.sv =====
`default_nettype none

package ipf_pkg;

    // Packet layout, counted in bytes from the first IPv4 header byte.
    localparam int IP_HDR_BYTES  = 20;
    localparam int UDP_HDR_BYTES = 8;
    localparam int HDR_END       = IP_HDR_BYTES + UDP_HDR_BYTES;

    // Byte position counter: header bytes, then two payload phases.
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_PROTO     = POS_W'(9);
    localparam logic [POS_W-1:0] POS_SRC_FIRST = POS_W'(12);
    localparam logic [POS_W-1:0] POS_SRC_SUM   = POS_W'(13);
    localparam logic [POS_W-1:0] POS_DST_FIRST = POS_W'(16);
    localparam logic [POS_W-1:0] POS_IP_END    = POS_W'(IP_HDR_BYTES);
    localparam logic [POS_W-1:0] POS_PORT_LO   = POS_W'(23);
    localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(25);
    localparam logic [POS_W-1:0] POS_HDR_LAST  = POS_W'(HDR_END - 1);
    localparam logic [POS_W-1:0] POS_PAY_HI    = POS_W'(HDR_END);
    localparam logic [POS_W-1:0] POS_PAY_LO    = POS_W'(HDR_END + 1);

    localparam logic [15:0] UDP_HDR_LEN = 16'(UDP_HDR_BYTES);
    localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_IP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT = 2'd2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] RST_SRC_IP   = 32'd167837962;
    localparam logic [31:0] RST_DST_IP   = 32'd167838152;
    localparam logic [15:0] RST_DST_PORT = 16'd42069;

    // Result queue between the parser and the verdict stage.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One pending result as classified by the parser.
    typedef struct packed {
        logic [7:0]  data;
        logic        byte_valid;
        logic        packet_end;
        logic        hdr_ok;
        logic [19:0] ip_sum;
        logic [31:0] udp_sum;
    } ipf_entry_t;

endpackage

`default_nettype wire

// ===== src/ipf_front.sv =====
`default_nettype none

module ipf_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         queue_full,
    input  wire logic [7:0]                   stream_byte,
    input  wire logic                         cfg_valid,
    input  wire logic [ipf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ipf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                              push,
    output ipf_pkg::ipf_entry_t               push_entry
);

    logic [31:0] src_cfg_reg;
    logic [31:0] dst_cfg_reg;
    logic [15:0] port_cfg_reg;

    logic [ipf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [19:0] ip_sum_reg, ip_sum_next;
    logic [31:0] udp_sum_reg, udp_sum_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] port_reg, port_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  hold_reg, hold_next;
    logic        len_bad_reg, len_bad_next;

    logic        accept;
    logic [15:0] word;
    logic [17:0] udp_add;
    logic [31:0] udp_upd;
    logic        finish;
    logic        last;

    assign accept = in_valid && !queue_full;
    assign word   = {hold_reg, stream_byte};

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cfg_reg  <= ipf_pkg::RST_SRC_IP;
            dst_cfg_reg  <= ipf_pkg::RST_DST_IP;
            port_cfg_reg <= ipf_pkg::RST_DST_PORT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ipf_pkg::CFG_SRC_IP:   src_cfg_reg  <= cfg_data[31:0];
                ipf_pkg::CFG_DST_IP:   dst_cfg_reg  <= cfg_data[31:0];
                ipf_pkg::CFG_DST_PORT: port_cfg_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Parser: walks the header, sums words and classifies each byte.
    always_comb
    begin
        pos_next     = pos_reg;
        ip_sum_next  = ip_sum_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        port_next    = port_reg;
        len_next     = len_reg;
        hold_next    = hold_reg;
        len_bad_next = len_bad_reg;
        udp_add      = '0;
        finish       = 1'b0;
        last         = (len_reg <= 16'd1);
        push         = 1'b0;
        push_entry.data       = '0;
        push_entry.byte_valid = 1'b0;
        push_entry.packet_end = 1'b0;

        if (pos_reg >= ipf_pkg::POS_PAY_HI)
        begin
            // Payload byte: always passed on, last one closes the packet.
            len_next              = len_reg - 16'd1;
            push                  = accept;
            push_entry.data       = stream_byte;
            push_entry.byte_valid = 1'b1;
            finish                = last;
            if (pos_reg == ipf_pkg::POS_PAY_HI)
            begin
                hold_next = stream_byte;
                pos_next  = ipf_pkg::POS_PAY_LO;
                if (last)
                begin
                    udp_add = {2'b00, stream_byte, 8'h00};
                end
            end
            else
            begin
                udp_add  = {2'b00, word};
                pos_next = ipf_pkg::POS_PAY_HI;
            end
        end
        else
        begin
            if (!pos_reg[0])
            begin
                hold_next = stream_byte;
            end
            else if (pos_reg < ipf_pkg::POS_IP_END)
            begin
                ip_sum_next = ip_sum_reg + 20'(word);
                if (pos_reg == ipf_pkg::POS_PROTO)
                begin
                    udp_add = {10'd0, stream_byte};
                end
                else if (pos_reg >= ipf_pkg::POS_SRC_SUM)
                begin
                    udp_add = {2'b00, word};
                end
            end
            else
            begin
                udp_add = {2'b00, word};
                if (pos_reg == ipf_pkg::POS_PORT_LO)
                begin
                    port_next = word;
                end
                if (pos_reg == ipf_pkg::POS_LEN_LO)
                begin
                    // Length enters the pseudo-header sum as well.
                    udp_add      = {1'b0, word, 1'b0};
                    len_next     = word;
                    len_bad_next = (word < ipf_pkg::UDP_HDR_LEN);
                end
            end

            if (pos_reg >= ipf_pkg::POS_SRC_FIRST && pos_reg < ipf_pkg::POS_DST_FIRST)
            begin
                src_next = {src_reg[23:0], stream_byte};
            end
            if (pos_reg >= ipf_pkg::POS_DST_FIRST && pos_reg < ipf_pkg::POS_IP_END)
            begin
                dst_next = {dst_reg[23:0], stream_byte};
            end

            if (pos_reg == ipf_pkg::POS_HDR_LAST)
            begin
                if (len_bad_reg || len_reg == ipf_pkg::UDP_HDR_LEN)
                begin
                    // Empty payload or short length: the verdict closes the packet right here.
                    finish = 1'b1;
                    push   = accept;
                end
                else
                begin
                    len_next = len_reg - ipf_pkg::UDP_HDR_LEN;
                    pos_next = ipf_pkg::POS_PAY_HI;
                end
            end
            else
            begin
                pos_next = pos_reg + ipf_pkg::POS_W'(1);
            end
        end

        udp_upd      = udp_sum_reg + 32'(udp_add);
        udp_sum_next = udp_upd;

        push_entry.packet_end = finish;
        push_entry.hdr_ok     = !len_bad_reg && (src_reg == src_cfg_reg)
                                && (dst_reg == dst_cfg_reg) && (port_reg == port_cfg_reg);
        push_entry.ip_sum     = ip_sum_reg;
        push_entry.udp_sum    = udp_upd;

        // Every packet end starts the next packet from a clean state.
        if (finish)
        begin
            pos_next     = '0;
            ip_sum_next  = '0;
            udp_sum_next = '0;
            src_next     = '0;
            dst_next     = '0;
            port_next    = '0;
            len_next     = '0;
            hold_next    = '0;
            len_bad_next = 1'b0;
        end
    end

    // Parser state advances only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            ip_sum_reg  <= '0;
            udp_sum_reg <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
            port_reg    <= '0;
            len_reg     <= '0;
            hold_reg    <= '0;
            len_bad_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            ip_sum_reg  <= ip_sum_next;
            udp_sum_reg <= udp_sum_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            port_reg    <= port_next;
            len_reg     <= len_next;
            hold_reg    <= hold_next;
            len_bad_reg <= len_bad_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ipf_queue.sv =====
`default_nettype none

module ipf_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ipf_pkg::ipf_entry_t push_entry,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output ipf_pkg::ipf_entry_t      head
);

    ipf_pkg::ipf_entry_t mem_reg [ipf_pkg::QUEUE_DEPTH];

    logic [ipf_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [ipf_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [ipf_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == ipf_pkg::QUEUE_CNT_W'(ipf_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + ipf_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ipf_pkg::QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + ipf_pkg::QUEUE_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - ipf_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ipf_back.sv =====
`default_nettype none

module ipf_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire ipf_pkg::ipf_entry_t head,
    input  wire logic                out_stall,
    output logic                     pop,
    output logic                     out_valid,
    output logic [7:0]               payload_byte,
    output logic                     byte_valid,
    output logic                     packet_end,
    output logic                     packet_keep
);

    logic       out_valid_reg;
    logic [7:0] payload_reg;
    logic       byte_valid_reg;
    logic       packet_end_reg;
    logic       packet_keep_reg;
    logic       keep;

    // True when the one's-complement fold of a sum is all ones.
    function automatic logic fold_is_ones(input logic [31:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = 17'(s[15:0]) + 17'(s[31:16]);
        s2 = 17'(s1[15:0]) + 17'(s1[16]);
        return (s2 == 17'(ipf_pkg::SUM_ALL_ONES));
    endfunction

    assign pop  = head_valid && (!out_valid_reg || !out_stall);
    assign keep = head.packet_end && head.hdr_ok
                  && fold_is_ones(32'(head.ip_sum)) && fold_is_ones(head.udp_sum);

    // Output register: loads a new result whenever the old one is gone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            payload_reg     <= head.data;
            byte_valid_reg  <= head.byte_valid;
            packet_end_reg  <= head.packet_end;
            packet_keep_reg <= keep;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_reg;
    assign byte_valid   = byte_valid_reg;
    assign packet_end   = packet_end_reg;
    assign packet_keep  = packet_keep_reg;

endmodule

`default_nettype wire

// ===== src/ipv4_udp_packet_filter.sv =====
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     stream_byte
// output    out        out_valid / out_stall   payload_byte, byte_valid, packet_end, packet_keep
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the parser sums it in that same cycle.
// A result passes through the result queue, then the output register.
// Header bytes other than the closing byte of an empty or short packet give no result.
// in_stall rises only when the two-entry result queue is full; cfg_ready is always high.
// Reset restores the match registers and starts parsing at the first header byte.
`default_nettype none

module ipv4_udp_packet_filter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      stream_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [7:0]                           payload_byte,
    output logic                                 byte_valid,
    output logic                                 packet_end,
    output logic                                 packet_keep,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ipf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ipf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                queue_full;
    logic                push;
    ipf_pkg::ipf_entry_t push_entry;
    logic                pop;
    logic                head_valid;
    ipf_pkg::ipf_entry_t head;

    assign in_stall  = queue_full;
    assign cfg_ready = 1'b1;

    // Parser and classifier.
    ipf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .queue_full (queue_full),
        .stream_byte(stream_byte),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_entry (push_entry)
    );

    // Result queue between the two sides.
    ipf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (head_valid),
        .head      (head)
    );

    // Verdict and output register.
    ipf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .out_stall   (out_stall),
        .pop         (pop),
        .out_valid   (out_valid),
        .payload_byte(payload_byte),
        .byte_valid  (byte_valid),
        .packet_end  (packet_end),
        .packet_keep (packet_keep)
    );

endmodule

`default_nettype wire

// ===== test/tb_ipv4_udp_packet_filter.sv =====
`timescale 1ns / 100ps

module tb_ipv4_udp_packet_filter;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    localparam logic [ipf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam logic [31:0] M_SRC  = ipf_pkg::RST_SRC_IP;
    localparam logic [31:0] M_DST  = ipf_pkg::RST_DST_IP;
    localparam logic [15:0] M_PORT = ipf_pkg::RST_DST_PORT;

    // How a checksum field is filled in when a packet is built.
    typedef enum logic [1:0] {CK_GOOD, CK_BAD, CK_ZERO, CK_RAND} csum_t;
    // Payload fill pattern.
    typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;
    // Verdict source for the closing byte of a packet.
    typedef enum logic [1:0] {V_PREDICT, V_KEEP, V_DROP} verdict_t;

    typedef struct packed {
        logic [7:0] data;
        verdict_t   verdict;
    } stream_item_t;

    typedef struct packed {
        logic [7:0] payload;
        logic       has_byte;
        logic       pkt_end;
        logic       keep;
    } filter_result_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] ulen;
        logic [7:0]  proto;
        csum_t       ip_ck;
        csum_t       udp_ck;
        fill_t       fill;
        verdict_t    verdict;
    } packet_row_t;

    // Hand-picked packets, sent with the match registers at their reset values.
    localparam packet_row_t DIRECTED_ROWS [16] = '{
        // Length of exactly eight: the packet closes on the last header byte.
        '{M_SRC, M_DST, 16'h1234, M_PORT, 16'd8, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_RAND, V_KEEP},
        // Odd payload length, one byte padded with a zero.
        '{M_SRC, M_DST, 16'h0400, M_PORT, 16'd9, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_ONES, V_KEEP},
        '{M_SRC, M_DST, 16'hBEEF, M_PORT, 16'd10, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_ONES, V_KEEP},
        // Short UDP length is always discarded.
        '{M_SRC, M_DST, 16'h1234, M_PORT, 16'd0, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_RAND, V_DROP},
        '{M_SRC, M_DST, 16'h1234, M_PORT, 16'd7, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_RAND, V_DROP},
        // Each checksum broken on its own.
        '{M_SRC, M_DST, 16'h1234, M_PORT, 16'd16, PROTO_UDP,
          CK_BAD, CK_GOOD, FILL_RAND, V_DROP},
        '{M_SRC, M_DST, 16'h1234, M_PORT, 16'd13, PROTO_UDP,
          CK_GOOD, CK_BAD, FILL_RAND, V_DROP},
        // Each match field off by one bit.
        '{M_SRC ^ 32'h1, M_DST, 16'h1234, M_PORT, 16'd12, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_RAND, V_DROP},
        '{M_SRC, M_DST ^ 32'h8000_0000, 16'h1234, M_PORT, 16'd12,
          PROTO_UDP, CK_GOOD, CK_GOOD, FILL_RAND, V_DROP},
        '{M_SRC, M_DST, 16'h1234, M_PORT ^ 16'h1, 16'd12, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_RAND, V_DROP},
        // A zero UDP checksum must still sum correctly.
        '{M_SRC, M_DST, 16'h1234, M_PORT, 16'd12, PROTO_UDP,
          CK_GOOD, CK_ZERO, FILL_RAND, V_PREDICT},
        // The protocol byte is summed but not checked.
        '{M_SRC, M_DST, 16'h0000, M_PORT, 16'd11, PROTO_TCP,
          CK_GOOD, CK_GOOD, FILL_ZERO, V_KEEP},
        '{M_SRC, M_DST, 16'hFFFF, M_PORT, 16'd40, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_ZERO, V_KEEP},
        '{M_SRC, M_DST, 16'h0001, M_PORT, 16'd120, PROTO_UDP,
          CK_GOOD, CK_GOOD, FILL_RAND, V_KEEP},
        '{M_SRC, M_DST, 16'h1234, M_PORT, 16'd8, PROTO_UDP,
          CK_BAD, CK_BAD, FILL_RAND, V_DROP},
        '{M_SRC, M_DST, 16'h1234, M_PORT, 16'd20, 8'hFF,
          CK_ZERO, CK_RAND, FILL_ONES, V_PREDICT}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] stream_byte = 8'h00;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] payload_byte;
    logic byte_valid;
    logic packet_end;
    logic packet_keep;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ipf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ipf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus and expectation stores.
    stream_item_t   tx_q[$];
    filter_result_t pending_results[$];
    verdict_t       in_verdict = V_PREDICT;
    int send_idle_pct = 13;
    int recv_stall_pct = 77;
    int failures = 0;
    int cycles = 0;

    // Match registers as the block should hold them.
    logic [31:0] want_src;
    logic [31:0] want_dst;
    logic [15:0] want_port;

    // Parser state of the predictor.
    logic [ipf_pkg::POS_W-1:0] parse_pos;
    logic [19:0] ip_acc;
    logic [31:0] udp_acc;
    logic [31:0] seen_src;
    logic [31:0] seen_dst;
    logic [15:0] seen_port;
    logic [15:0] len_left;
    logic [7:0]  hi_byte;
    logic        short_len;

    ipv4_udp_packet_filter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .packet_end   (packet_end),
        .packet_keep  (packet_keep),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // One's-complement fold of a word sum, two rounds.
    function automatic logic [19:0] fold_sum(input logic [31:0] s);
        logic [31:0] t;
        t = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
        return t[19:0];
    endfunction

    task automatic clear_parser();
        parse_pos = '0;
        ip_acc    = '0;
        udp_acc   = '0;
        seen_src  = '0;
        seen_dst  = '0;
        seen_port = '0;
        len_left  = '0;
        hi_byte   = '0;
        short_len = 1'b0;
    endtask

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // Advance the filter by one stream byte and queue the result it causes.
    task automatic filter_byte(input logic [7:0] b, input verdict_t verdict);
        logic [15:0] word;
        logic        emit;
        logic        closes;
        logic        has_byte;
        logic        last;
        filter_result_t r;
        word = {hi_byte, b};
        emit = 1'b0;
        closes = 1'b0;
        has_byte = 1'b0;
        if (parse_pos >= ipf_pkg::POS_PAY_HI)
        begin
            // Payload: bytes pair up into words, the last one padded.
            last = (len_left <= 16'd1);
            len_left = len_left - 16'd1;
            emit = 1'b1;
            has_byte = 1'b1;
            if (parse_pos == ipf_pkg::POS_PAY_HI)
            begin
                hi_byte = b;
                parse_pos = ipf_pkg::POS_PAY_LO;
                if (last)
                begin
                    udp_acc = udp_acc + {16'd0, b, 8'd0};
                    closes = 1'b1;
                end
            end
            else
            begin
                udp_acc = udp_acc + {16'd0, word};
                parse_pos = ipf_pkg::POS_PAY_HI;
                closes = last;
            end
        end
        else
        begin
            // Header: sums on every odd byte, fields captured on the way.
            if (!parse_pos[0])
                hi_byte = b;
            else if (parse_pos < ipf_pkg::POS_IP_END)
            begin
                ip_acc = ip_acc + {4'd0, word};
                if (parse_pos == ipf_pkg::POS_PROTO)
                    udp_acc = udp_acc + {24'd0, b};
                if (parse_pos >= ipf_pkg::POS_SRC_SUM)
                    udp_acc = udp_acc + {16'd0, word};
            end
            else
            begin
                udp_acc = udp_acc + {16'd0, word};
                if (parse_pos == ipf_pkg::POS_PORT_LO)
                    seen_port = word;
                if (parse_pos == ipf_pkg::POS_LEN_LO)
                begin
                    udp_acc = udp_acc + {16'd0, word};
                    len_left = word;
                    short_len = (word < ipf_pkg::UDP_HDR_LEN);
                end
            end
            if (parse_pos >= ipf_pkg::POS_SRC_FIRST && parse_pos < ipf_pkg::POS_DST_FIRST)
                seen_src = {seen_src[23:0], b};
            if (parse_pos >= ipf_pkg::POS_DST_FIRST && parse_pos < ipf_pkg::POS_IP_END)
                seen_dst = {seen_dst[23:0], b};
            if (parse_pos == ipf_pkg::POS_HDR_LAST)
            begin
                if (short_len || len_left == ipf_pkg::UDP_HDR_LEN)
                begin
                    emit = 1'b1;
                    closes = 1'b1;
                end
                else
                begin
                    len_left = len_left - ipf_pkg::UDP_HDR_LEN;
                    parse_pos = ipf_pkg::POS_PAY_HI;
                end
            end
            else
                parse_pos = parse_pos + ipf_pkg::POS_W'(1);
        end

        if (emit)
        begin
            r.payload  = has_byte ? b : 8'h00;
            r.has_byte = has_byte;
            r.pkt_end  = closes;
            r.keep     = 1'b0;
            if (closes)
            begin
                r.keep = !short_len
                    && fold_sum({12'd0, ip_acc}) == {4'd0, ipf_pkg::SUM_ALL_ONES}
                    && fold_sum(udp_acc) == {4'd0, ipf_pkg::SUM_ALL_ONES}
                    && seen_src == want_src
                    && seen_dst == want_dst
                    && seen_port == want_port;
                if (verdict == V_KEEP)
                    r.keep = 1'b1;
                else if (verdict == V_DROP)
                    r.keep = 1'b0;
                clear_parser();
            end
            pending_results.push_back(r);
        end
    endtask

    function automatic logic [15:0] fill_checksum(input logic [15:0] good, input csum_t kind);
        case (kind)
            CK_GOOD: return good;
            // A single flipped bit can never fold back to a valid sum.
            CK_BAD:  return good ^ (16'h1 << $urandom_range(15));
            CK_ZERO: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build one packet with its checksums and queue its bytes for sending.
    task automatic add_packet(input logic [31:0] src, input logic [31:0] dst,
                              input logic [15:0] sport, input logic [15:0] dport,
                              input logic [15:0] ulen, input logic [7:0] proto,
                              input csum_t ip_ck, input csum_t udp_ck,
                              input fill_t fill, input verdict_t verdict);
        logic [7:0]  pkt[$];
        logic [31:0] sum;
        logic [19:0] folded;
        logic [15:0] csum;
        logic [7:0]  lo_byte;
        int plen;
        stream_item_t item;
        plen = (ulen > ipf_pkg::UDP_HDR_LEN) ? int'(ulen) - ipf_pkg::UDP_HDR_BYTES : 0;

        // IPv4 header; the fields the block ignores are random.
        for (int i = 0; i < 9; i++)
            pkt.push_back(8'($urandom));
        pkt.push_back(proto);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(src[i*8 +: 8]);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(dst[i*8 +: 8]);

        // UDP header and payload.
        pkt.push_back(sport[15:8]);
        pkt.push_back(sport[7:0]);
        pkt.push_back(dport[15:8]);
        pkt.push_back(dport[7:0]);
        pkt.push_back(ulen[15:8]);
        pkt.push_back(ulen[7:0]);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        for (int i = 0; i < plen; i++)
        begin
            case (fill)
                FILL_ZERO: pkt.push_back(8'h00);
                FILL_ONES: pkt.push_back(8'hFF);
                default:   pkt.push_back(8'($urandom));
            endcase
        end

        // IPv4 header checksum.
        sum = '0;
        for (int i = 0; i < ipf_pkg::IP_HDR_BYTES; i += 2)
            sum = sum + {16'd0, pkt[i], pkt[i+1]};
        folded = fold_sum(sum);
        csum = fill_checksum(~folded[15:0], ip_ck);
        pkt[10] = csum[15:8];
        pkt[11] = csum[7:0];

        // UDP checksum over the pseudo-header, header and padded payload.
        sum = {16'd0, src[31:16]} + {16'd0, src[15:0]} + {16'd0, dst[31:16]}
            + {16'd0, dst[15:0]} + {24'd0, proto} + {16'd0, ulen}
            + {16'd0, sport} + {16'd0, dport} + {16'd0, ulen};
        for (int i = 0; i < plen; i += 2)
        begin
            lo_byte = (i + 1 < plen) ? pkt[ipf_pkg::HDR_END+i+1] : 8'h00;
            sum = sum + {16'd0, pkt[ipf_pkg::HDR_END+i], lo_byte};
        end
        folded = fold_sum(sum);
        csum = fill_checksum(~folded[15:0], udp_ck);
        pkt[26] = csum[15:8];
        pkt[27] = csum[7:0];

        foreach (pkt[i])
        begin
            item.data = pkt[i];
            item.verdict = (i == pkt.size() - 1) ? verdict : V_PREDICT;
            tx_q.push_back(item);
        end
    endtask

    // Mostly well-formed packets aimed at the current match registers, plus
    // broken checksums, near-miss fields, short lengths and random headers.
    task automatic random_traffic(input int budget);
        int queued;
        int pick;
        int pattern;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] dport;
        logic [15:0] ulen;
        logic [7:0]  proto;
        csum_t ip_ck;
        csum_t udp_ck;
        fill_t fill;
        queued = 0;
        while (queued < budget)
        begin
            pick = $urandom_range(99);
            pattern = $urandom_range(19);
            src = want_src;
            dst = want_dst;
            dport = want_port;
            proto = PROTO_UDP;
            ip_ck = CK_GOOD;
            udp_ck = CK_GOOD;
            ulen = ($urandom_range(19) == 0) ? 16'($urandom_range(33, 300))
                                             : 16'($urandom_range(8, 32));
            fill = (pattern == 0) ? FILL_ZERO : (pattern == 1) ? FILL_ONES : FILL_RAND;
            if (pick < 10)
                ip_ck = CK_BAD;
            else if (pick < 20)
                udp_ck = CK_BAD;
            else if (pick < 24)
                src = src ^ (32'h1 << $urandom_range(31));
            else if (pick < 28)
                dst = dst ^ (32'h1 << $urandom_range(31));
            else if (pick < 32)
                dport = dport ^ (16'h1 << $urandom_range(15));
            else if (pick < 37)
                ulen = 16'($urandom_range(7));
            else if (pick < 45)
            begin
                src = $urandom;
                dst = $urandom;
                dport = 16'($urandom);
                proto = 8'($urandom);
                ulen = 16'($urandom_range(40));
                ip_ck = CK_RAND;
                udp_ck = CK_RAND;
            end
            else if (pick < 50)
                proto = 8'($urandom);
            add_packet(src, dst, 16'($urandom), dport, ulen, proto, ip_ck, udp_ck,
                       fill, V_PREDICT);
            queued += ipf_pkg::HDR_END
                + ((ulen > ipf_pkg::UDP_HDR_LEN) ? int'(ulen) - ipf_pkg::UDP_HDR_BYTES : 0);
        end
    endtask

    // Wait until every byte is in and every result is out.
    task automatic wait_idle();
        while (tx_q.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [ipf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipf_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ipf_pkg::CFG_SRC_IP:   want_src = data;
            ipf_pkg::CFG_DST_IP:   want_dst = data;
            ipf_pkg::CFG_DST_PORT: want_port = data[15:0];
            default:      ;
        endcase
    endtask

    // Input side: one stream byte per request, with random gaps.
    always @(posedge clk)
    begin
        stream_item_t item;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                filter_byte(stream_byte, in_verdict);
            if (!in_valid || !in_stall)
            begin
                if (tx_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item = tx_q.pop_front();
                    in_valid    <= 1'b1;
                    stream_byte <= item.data;
                    in_verdict  <= item.verdict;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, and every accepted request is checked.
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    note_failure($sformatf(
                        "unexpected result: byte %02h valid %0b end %0b keep %0b",
                        payload_byte, byte_valid, packet_end, packet_keep));
                else
                begin
                    want = pending_results.pop_front();
                    if (payload_byte !== want.payload || byte_valid !== want.has_byte
                        || packet_end !== want.pkt_end || packet_keep !== want.keep)
                        note_failure($sformatf(
                            {"mismatch: expected byte %02h valid %0b end %0b keep %0b, ",
                             "got %02h %0b %0b %0b"},
                            want.payload, want.has_byte, want.pkt_end, want.keep,
                            payload_byte, byte_valid, packet_end, packet_keep));
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("ipv4_udp_packet_filter verification failed");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        want_src  = ipf_pkg::RST_SRC_IP;
        want_dst  = ipf_pkg::RST_DST_IP;
        want_port = ipf_pkg::RST_DST_PORT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // An unused index must leave the reset matches in place.
        cfg_write(CFG_UNUSED, 32'h0000_0000);
        foreach (DIRECTED_ROWS[i])
            add_packet(DIRECTED_ROWS[i].src, DIRECTED_ROWS[i].dst, DIRECTED_ROWS[i].sport,
                       DIRECTED_ROWS[i].dport, DIRECTED_ROWS[i].ulen, DIRECTED_ROWS[i].proto,
                       DIRECTED_ROWS[i].ip_ck, DIRECTED_ROWS[i].udp_ck,
                       DIRECTED_ROWS[i].fill, DIRECTED_ROWS[i].verdict);
        wait_idle();

        // All-zero matches, slow receiver; the sender drains once midway.
        cfg_write(ipf_pkg::CFG_SRC_IP, 32'h0000_0000);
        cfg_write(ipf_pkg::CFG_DST_IP, 32'h0000_0000);
        cfg_write(ipf_pkg::CFG_DST_PORT, 32'hFFFF_0000);
        random_traffic(180);
        wait_idle();
        random_traffic(180);
        wait_idle();

        // All-ones matches, slow sender.
        send_idle_pct = 77;
        recv_stall_pct = 13;
        cfg_write(ipf_pkg::CFG_SRC_IP, 32'hFFFF_FFFF);
        cfg_write(ipf_pkg::CFG_DST_IP, 32'hFFFF_FFFF);
        cfg_write(ipf_pkg::CFG_DST_PORT, 32'h0000_FFFF);
        random_traffic(280);
        wait_idle();

        // Random matches at full rate.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_write(ipf_pkg::CFG_SRC_IP, $urandom);
        cfg_write(ipf_pkg::CFG_DST_IP, $urandom);
        cfg_write(ipf_pkg::CFG_DST_PORT, $urandom);
        cfg_write(CFG_UNUSED, $urandom);
        random_traffic(280);
        wait_idle();

        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (failures == 0)
            $display("ipv4_udp_packet_filter verification clean");
        else
            $display("ipv4_udp_packet_filter verification failed");
        $finish;
    end

endmodule
